[sv/dfs_pkg.sv]
// Shared types and constants for the depth-first spanning forest block.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package dfs_pkg;

    localparam int MAX_VERTS = 16;
    localparam int VIDX_W    = $clog2(MAX_VERTS);
    localparam int DEPTH_W   = $clog2(MAX_VERTS + 1);
    localparam int VERT_W    = 5;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

    localparam logic [VERT_W-1:0] VCOUNT_RESET = VERT_W'(MAX_VERTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_WALK,
        ST_EMIT
    } dfs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic add;
        logic run_start;
        logic root_step;
        logic walk_step;
        logic emit_load;
    } dfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic root_done;
        logic root_visited;
        logic depth_zero;
        logic emit_done;
        logic out_free;
    } dfs_stat_t;

endpackage

[sv/dfs_spanning_forest.sv]
// Clear and add-edge commands are accepted back to back.
// A run scans the row of each visited vertex's frame one index at a time and pops
// the frame once the index runs past the n vertices in use.
// Results then leave at one beat per cycle while m_ready is high, n beats per run.
// aresetn is synchronous, active low: it clears the adjacency matrix and visit marks,
// sets vertex_count to 16 and drops m_valid; no clearing pass is needed.
//
// Top level of the depth-first spanning forest block.
// Depends on dfs_pkg, dfs_ctrl and dfs_datapath.
module dfs_spanning_forest (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Configuration write channel: the vertex_count register.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dfs_pkg::VERT_W-1:0]    cfg_vertex_count,

    // Command channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dfs_pkg::CMD_W-1:0]     s_cmd,
    input  logic [dfs_pkg::VERT_W-1:0]    s_end_a,
    input  logic [dfs_pkg::VERT_W-1:0]    s_end_b,

    // Result channel: one beat per vertex after a run.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dfs_pkg::VERT_W-1:0]    m_vertex,
    output logic [dfs_pkg::VERT_W-1:0]    m_parent_vertex,
    output logic                          m_last
);

    dfs_pkg::dfs_cmd_t  cmd;
    dfs_pkg::dfs_stat_t stat;

    // The register is only sampled when a run starts, so a write can always be taken;
    // the host must write it only while the block is idle; the block does not check.
    assign cfg_ready = 1'b1;

    // The controller accepts a command only in its idle state. A run walks
    // the roots in ascending order; every unvisited root opens a tree whose
    // frames live on the stack, and each walk cycle examines one neighbor
    // index of the top frame: a hit pushes the neighbor, running past the
    // last vertex pops the frame. After the walk the parent table is read
    // out in vertex order into the result register.
    dfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The result register separates the two sides: a new command can be
    // taken while the final beat of a run still waits for m_ready, and
    // the emit step of a later run waits until the register is free.
    dfs_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .end_a            (s_end_a),
        .end_b            (s_end_b),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_vertex_count (cfg_vertex_count),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .out_vertex       (m_vertex),
        .out_parent       (m_parent_vertex),
        .out_last         (m_last)
    );

endmodule

[sv/dfs_ctrl.sv]
// Controller state machine for the depth-first spanning forest block.
// Depends on dfs_pkg for the state type, command codes and control structs.
module dfs_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic [dfs_pkg::CMD_W-1:0]    s_cmd,
    output logic                         s_ready,
    input  dfs_pkg::dfs_stat_t           stat,
    output dfs_pkg::dfs_cmd_t            cmd
);

    dfs_pkg::dfs_state_t state_reg;
    dfs_pkg::dfs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dfs_pkg::ST_IDLE: begin
                if (s_valid && (s_cmd == dfs_pkg::CMD_RUN)) begin
                    state_next = dfs_pkg::ST_ROOT;
                end
            end
            dfs_pkg::ST_ROOT: begin
                if (stat.root_done) begin
                    state_next = dfs_pkg::ST_EMIT;
                end else if (!stat.root_visited) begin
                    state_next = dfs_pkg::ST_WALK;
                end
            end
            dfs_pkg::ST_WALK: begin
                if (stat.depth_zero) begin
                    state_next = dfs_pkg::ST_ROOT;
                end
            end
            dfs_pkg::ST_EMIT: begin
                if (stat.emit_done) begin
                    state_next = dfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            dfs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_cmd)
                        dfs_pkg::CMD_CLEAR: cmd.clear     = 1'b1;
                        dfs_pkg::CMD_ADD:   cmd.add       = 1'b1;
                        dfs_pkg::CMD_RUN:   cmd.run_start = 1'b1;
                        default:            cmd           = '0;
                    endcase
                end
            end
            dfs_pkg::ST_ROOT: begin
                cmd.root_step = !stat.root_done;
            end
            dfs_pkg::ST_WALK: begin
                cmd.walk_step = !stat.depth_zero;
            end
            dfs_pkg::ST_EMIT: begin
                cmd.emit_load = !stat.emit_done && stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/dfs_datapath.sv]
// Datapath of the depth-first spanning forest block: adjacency matrix, visit
// marks, parent table, walk stack, counters and the result register.
// Depends on dfs_pkg; driven by dfs_ctrl through dfs_cmd_t.
module dfs_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dfs_pkg::dfs_cmd_t             cmd,
    output dfs_pkg::dfs_stat_t            stat,
    input  logic [dfs_pkg::VERT_W-1:0]    end_a,
    input  logic [dfs_pkg::VERT_W-1:0]    end_b,
    input  logic                          cfg_write,
    input  logic [dfs_pkg::VERT_W-1:0]    cfg_vertex_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dfs_pkg::VERT_W-1:0]    out_vertex,
    output logic [dfs_pkg::VERT_W-1:0]    out_parent,
    output logic                          out_last
);

    localparam int NV = dfs_pkg::MAX_VERTS;
    localparam int VW = dfs_pkg::VERT_W;
    localparam int IW = dfs_pkg::VIDX_W;
    localparam int DW = dfs_pkg::DEPTH_W;
    localparam logic [VW-1:0] ONE_V = VW'(1);
    localparam logic [DW-1:0] ONE_D = DW'(1);

    // Control state, cleared by reset.
    logic [NV-1:0] adj_reg [NV];
    logic [NV-1:0] adj_next [NV];
    logic [NV-1:0] visited_reg, visited_next;
    logic [VW-1:0] vcount_reg, vcount_next;
    logic [VW-1:0] n_reg, n_next;
    logic [VW-1:0] root_reg, root_next;
    logic [VW-1:0] emit_reg, emit_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          out_valid_reg, out_valid_next;

    // Payload state, no reset.
    logic [VW-1:0] parent_reg [NV];
    logic [VW-1:0] parent_next [NV];
    logic [VW-1:0] stk_vert_reg [NV];
    logic [VW-1:0] stk_vert_next [NV];
    logic [VW-1:0] stk_next_reg [NV];
    logic [VW-1:0] stk_next_next [NV];
    logic [VW-1:0] out_vertex_reg, out_vertex_next;
    logic [VW-1:0] out_parent_reg, out_parent_next;
    logic          out_last_reg, out_last_next;

    logic          a_ok, b_ok;
    logic [IW-1:0] a_idx, b_idx;
    logic [IW-1:0] root_idx, emit_idx, top_idx, push_idx, u_idx, i_idx;
    logic [VW-1:0] a_m1, b_m1, root_m1, emit_m1, u_m1, i_m1;
    logic [DW-1:0] top_d;
    logic [VW-1:0] top_u, top_i;
    logic [NV-1:0] top_row;
    logic          i_in_range, hit;

    assign a_ok     = (end_a != '0) && (end_a <= VW'(NV));
    assign b_ok     = (end_b != '0) && (end_b <= VW'(NV));
    assign a_m1     = end_a - ONE_V;
    assign b_m1     = end_b - ONE_V;
    assign a_idx    = a_m1[IW-1:0];
    assign b_idx    = b_m1[IW-1:0];
    assign root_m1  = root_reg - ONE_V;
    assign root_idx = root_m1[IW-1:0];
    assign emit_m1  = emit_reg - ONE_V;
    assign emit_idx = emit_m1[IW-1:0];

    // Top frame of the walk stack and the adjacency row of its vertex.
    assign top_d      = depth_reg - ONE_D;
    assign top_idx    = top_d[IW-1:0];
    assign push_idx   = depth_reg[IW-1:0];
    assign top_u      = stk_vert_reg[top_idx];
    assign top_i      = stk_next_reg[top_idx];
    assign u_m1       = top_u - ONE_V;
    assign u_idx      = u_m1[IW-1:0];
    assign i_m1       = top_i - ONE_V;
    assign i_idx      = i_m1[IW-1:0];
    assign top_row    = adj_reg[u_idx];
    assign i_in_range = (top_i <= n_reg);
    assign hit        = i_in_range && top_row[i_idx] && !visited_reg[i_idx];

    always_comb begin
        adj_next        = adj_reg;
        visited_next    = visited_reg;
        vcount_next     = vcount_reg;
        n_next          = n_reg;
        root_next       = root_reg;
        emit_next       = emit_reg;
        depth_next      = depth_reg;
        parent_next     = parent_reg;
        stk_vert_next   = stk_vert_reg;
        stk_next_next   = stk_next_reg;
        out_vertex_next = out_vertex_reg;
        out_parent_next = out_parent_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cfg_write) begin
            vcount_next = cfg_vertex_count;
        end

        if (cmd.clear) begin
            for (int r = 0; r < NV; r++) begin
                adj_next[r] = '0;
            end
        end

        if (cmd.add && a_ok && b_ok) begin
            adj_next[a_idx][b_idx] = 1'b1;
            adj_next[b_idx][a_idx] = 1'b1;
        end

        if (cmd.run_start) begin
            n_next       = (vcount_reg > VW'(NV)) ? VW'(NV) : vcount_reg;
            visited_next = '0;
            root_next    = ONE_V;
            emit_next    = ONE_V;
            depth_next   = '0;
        end

        // A root that is still unvisited opens a new tree with a single frame.
        if (cmd.root_step) begin
            if (!visited_reg[root_idx]) begin
                visited_next[root_idx] = 1'b1;
                parent_next[root_idx]  = '0;
                stk_vert_next[0]       = root_reg;
                stk_next_next[0]       = ONE_V;
                depth_next             = ONE_D;
            end
            root_next = root_reg + ONE_V;
        end

        // One neighbor index of the top frame is examined per step.
        if (cmd.walk_step) begin
            if (!i_in_range) begin
                depth_next = depth_reg - ONE_D;
            end else begin
                stk_next_next[top_idx] = top_i + ONE_V;
                if (hit) begin
                    visited_next[i_idx] = 1'b1;
                    parent_next[i_idx]  = top_u;
                    if (depth_reg < DW'(NV)) begin
                        stk_vert_next[push_idx] = top_i;
                        stk_next_next[push_idx] = ONE_V;
                        depth_next              = depth_reg + ONE_D;
                    end
                end
            end
        end

        if (cmd.emit_load) begin
            out_vertex_next = emit_reg;
            out_parent_next = parent_reg[emit_idx];
            out_last_next   = (emit_reg == n_reg);
            out_valid_next  = 1'b1;
            emit_next       = emit_reg + ONE_V;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NV; r++) begin
                adj_reg[r] <= '0;
            end
            visited_reg   <= '0;
            vcount_reg    <= dfs_pkg::VCOUNT_RESET;
            n_reg         <= '0;
            root_reg      <= ONE_V;
            emit_reg      <= ONE_V;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            adj_reg       <= adj_next;
            visited_reg   <= visited_next;
            vcount_reg    <= vcount_next;
            n_reg         <= n_next;
            root_reg      <= root_next;
            emit_reg      <= emit_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        parent_reg     <= parent_next;
        stk_vert_reg   <= stk_vert_next;
        stk_next_reg   <= stk_next_next;
        out_vertex_reg <= out_vertex_next;
        out_parent_reg <= out_parent_next;
        out_last_reg   <= out_last_next;
    end

    assign stat.root_done    = (root_reg > n_reg);
    assign stat.root_visited = visited_reg[root_idx];
    assign stat.depth_zero   = (depth_reg == '0);
    assign stat.emit_done    = (emit_reg > n_reg);
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_vertex = out_vertex_reg;
    assign out_parent = out_parent_reg;
    assign out_last   = out_last_reg;

endmodule

[sv/dfs_checker.sv]
// Port-level checker for the depth-first spanning forest block, with its bind.
// Depends on dfs_pkg and on the port list of dfs_spanning_forest.
module dfs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [dfs_pkg::VERT_W-1:0]    cfg_vertex_count,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [dfs_pkg::CMD_W-1:0]     s_cmd,
    input logic [dfs_pkg::VERT_W-1:0]    s_end_a,
    input logic [dfs_pkg::VERT_W-1:0]    s_end_b,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [dfs_pkg::VERT_W-1:0]    m_vertex,
    input logic [dfs_pkg::VERT_W-1:0]    m_parent_vertex,
    input logic                          m_last
);

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex)
            && $stable(m_parent_vertex) && $stable(m_last))
        else $error("result beat changed while stalled");

    // While a run is still emitting, no new command is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("command accepted in the middle of a result burst");

    // A reported vertex is in range and is never its own parent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_vertex != '0) && (m_vertex <= dfs_pkg::VERT_W'(dfs_pkg::MAX_VERTS))
            && (m_parent_vertex != m_vertex))
        else $error("bad vertex or parent in result beat");

    // Consecutive beats of one run report consecutive vertices.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last ##1 m_valid |-> m_vertex == $past(m_vertex) + 1'b1)
        else $error("result vertices out of order");

endmodule

bind dfs_spanning_forest dfs_checker u_dfs_checker (.*);

[sim/tb_dfs_spanning_forest.sv]
// Self-checking testbench for dfs_spanning_forest: drives clear, add-edge and run
// commands, predicts the parent of every vertex and checks each result beat.
// Depends on dfs_pkg and the dfs_spanning_forest RTL.
`timescale 1ns / 100ps

module tb_dfs_spanning_forest;

    // The command field has one code the block does not use; it must be ignored.
    localparam logic [dfs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Quiet cycles after the last predicted beat; enough for any command to finish,
    // even a run with 16 vertices that has not yet produced its first beat.
    localparam int SETTLE_CYCLES = 400;

    // Long hold-off of the result channel used to fill the block up.
    localparam int HOLD_OFF_CYCLES = 1500;

    typedef struct packed {
        logic [dfs_pkg::VERT_W-1:0] vertex;
        logic [dfs_pkg::VERT_W-1:0] parent_vertex;
        logic                       last;
    } parent_beat_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [dfs_pkg::VERT_W-1:0] cfg_vertex_count;
    logic                       s_valid;
    logic                       s_ready;
    logic [dfs_pkg::CMD_W-1:0]  s_cmd;
    logic [dfs_pkg::VERT_W-1:0] s_end_a;
    logic [dfs_pkg::VERT_W-1:0] s_end_b;
    logic                       m_valid;
    logic                       m_ready;
    logic [dfs_pkg::VERT_W-1:0] m_vertex;
    logic [dfs_pkg::VERT_W-1:0] m_parent_vertex;
    logic                       m_last;

    // Shadow copy of the graph and of the vertex_count register.
    logic [dfs_pkg::MAX_VERTS-1:0] edge_rows [dfs_pkg::MAX_VERTS];
    logic [dfs_pkg::VERT_W-1:0]    vcount_shadow;

    // Parent beats predicted for runs that were accepted but not yet seen.
    parent_beat_t parents_due [$];

    int mismatch_count;
    int beats_seen;
    int items_sent;
    int burst_left;
    int hold_req;

    dfs_spanning_forest dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_vertex_count (cfg_vertex_count),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_end_a          (s_end_a),
        .s_end_b          (s_end_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_vertex         (m_vertex),
        .m_parent_vertex  (m_parent_vertex),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs. The slowest legal run is far below this.
    initial begin
        #(20_000_000);
        $display("Mismatches found");
        $finish;
    end

    // Every mismatch goes through here: one line is printed and it is counted.
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        mismatch_count++;
    endtask

    // Depth-first spanning forest over the shadow graph. Roots are tried in
    // ascending order, neighbors are scanned in ascending order, and the
    // recursion is an explicit stack of frames (vertex, next index to scan).
    // Edges to vertices above the count in use are never looked at, and a self
    // loop is harmless because the vertex is already marked when it is scanned.
    function automatic void predict_forest();
        int                            n;
        int                            top;
        int                            u;
        int                            i;
        int                            depth;
        bit                            pushed;
        logic [dfs_pkg::MAX_VERTS-1:0] seen;
        logic [dfs_pkg::VERT_W-1:0]    parent_of [dfs_pkg::MAX_VERTS];
        int                            frame_vert [dfs_pkg::MAX_VERTS];
        int                            frame_next [dfs_pkg::MAX_VERTS];
        parent_beat_t                  beat;

        // A count above the storage size saturates; a count of zero walks nothing.
        n = (vcount_shadow > dfs_pkg::MAX_VERTS) ? dfs_pkg::MAX_VERTS : int'(vcount_shadow);
        seen = '0;
        for (int k = 0; k < dfs_pkg::MAX_VERTS; k++) begin
            parent_of[k] = '0;
        end

        for (int root = 1; root <= n; root++) begin
            if (!seen[root-1]) begin
                seen[root-1]      = 1'b1;
                parent_of[root-1] = '0;
                frame_vert[0]     = root;
                frame_next[0]     = 1;
                depth             = 1;
                while (depth > 0) begin
                    top    = depth - 1;
                    u      = frame_vert[top];
                    i      = frame_next[top];
                    pushed = 1'b0;
                    while (i <= n && !pushed) begin
                        if (edge_rows[u-1][i-1] && !seen[i-1]) begin
                            frame_next[top] = i + 1;
                            seen[i-1]       = 1'b1;
                            parent_of[i-1]  = dfs_pkg::VERT_W'(u);
                            if (depth < dfs_pkg::MAX_VERTS) begin
                                frame_vert[depth] = i;
                                frame_next[depth] = 1;
                                depth++;
                            end
                            pushed = 1'b1;
                        end else begin
                            i++;
                        end
                    end
                    if (!pushed) begin
                        depth--;
                    end
                end
            end
        end

        for (int v = 1; v <= n; v++) begin
            beat.vertex        = dfs_pkg::VERT_W'(v);
            beat.parent_vertex = parent_of[v-1];
            beat.last          = (v == n);
            parents_due.push_back(beat);
        end
    endfunction

    // Offers one command beat and waits for it to be taken. The sender works in
    // bursts: when a burst runs out, valid drops for a random gap, possibly none. Inside a burst
    // valid stays high and only the payload changes at the falling edge.
    // The shadow model is updated at the edge where the beat is accepted.
    task automatic send_command(input logic [dfs_pkg::CMD_W-1:0] cmd,
                                input logic [dfs_pkg::VERT_W-1:0] a,
                                input logic [dfs_pkg::VERT_W-1:0] b);
        int gap;

        @(negedge aclk);
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_cmd   = cmd;
        s_end_a = a;
        s_end_b = b;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        items_sent++;

        case (cmd)
            dfs_pkg::CMD_CLEAR: begin
                for (int k = 0; k < dfs_pkg::MAX_VERTS; k++) begin
                    edge_rows[k] = '0;
                end
            end
            dfs_pkg::CMD_ADD: begin
                // Endpoints outside 1..MAX_VERTS make the whole command a no-op.
                if (a != 0 && b != 0 && a <= dfs_pkg::MAX_VERTS
                        && b <= dfs_pkg::MAX_VERTS) begin
                    edge_rows[a-1][b-1] = 1'b1;
                    edge_rows[b-1][a-1] = 1'b1;
                end
            end
            dfs_pkg::CMD_RUN: begin
                predict_forest();
            end
            default: begin
                // The unused code changes nothing and produces no beat.
            end
        endcase
    endtask

    // Stops offering commands, waits for every predicted beat and then lets the
    // block finish anything that produces no beat (a run with zero vertices,
    // a trailing clear or add).
    task automatic settle_block();
        @(negedge aclk);
        s_valid    = 1'b0;
        burst_left = 0;
        while (parents_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The register is only written when the block has gone quiet.
    task automatic write_vertex_count(input logic [dfs_pkg::VERT_W-1:0] count);
        settle_block();
        @(negedge aclk);
        cfg_vertex_count = count;
        cfg_valid        = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        vcount_shadow = count;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Endpoint that the block must reject: zero or above the storage size.
    function automatic logic [dfs_pkg::VERT_W-1:0] bad_endpoint();
        if ($urandom_range(0, 1) == 0) begin
            return '0;
        end
        return dfs_pkg::VERT_W'($urandom_range(dfs_pkg::MAX_VERTS + 1, 31));
    endfunction

    // One item that a well-formed sequence would not contain.
    task automatic send_noise(input int vc);
        logic [dfs_pkg::VERT_W-1:0] a;
        logic [dfs_pkg::VERT_W-1:0] b;

        case ($urandom_range(0, 3))
            0: begin
                send_command(CMD_UNUSED, dfs_pkg::VERT_W'($urandom_range(0, 31)),
                             dfs_pkg::VERT_W'($urandom_range(0, 31)));
            end
            1: begin
                a = bad_endpoint();
                b = dfs_pkg::VERT_W'($urandom_range(0, 31));
                if ($urandom_range(0, 1) == 0) begin
                    send_command(dfs_pkg::CMD_ADD, a, b);
                end else begin
                    send_command(dfs_pkg::CMD_ADD, b, a);
                end
            end
            2: begin
                // An edge to a vertex outside the count is stored but not walked; at the full count it is a self loop.
                a = dfs_pkg::VERT_W'($urandom_range(1, vc));
                b = (vc < dfs_pkg::MAX_VERTS)
                    ? dfs_pkg::VERT_W'($urandom_range(vc + 1, dfs_pkg::MAX_VERTS)) : a;
                send_command(dfs_pkg::CMD_ADD, b, a);
            end
            default: begin
                a = dfs_pkg::VERT_W'($urandom_range(1, dfs_pkg::MAX_VERTS));
                send_command(dfs_pkg::CMD_ADD, a, a);
            end
        endcase
    endtask

    // One well-formed sequence: usually a clear, then a graph of random shape
    // over vertices 1..vc, with the odd piece of noise mixed in, then a run.
    task automatic graph_round(input int vc);
        int shape;
        int count;
        int center;
        int swap_at;
        int held;
        int order [dfs_pkg::MAX_VERTS];

        if ($urandom_range(0, 4) != 0) begin
            send_command(dfs_pkg::CMD_CLEAR, dfs_pkg::VERT_W'($urandom_range(0, 31)),
                         dfs_pkg::VERT_W'($urandom_range(0, 31)));
        end
        shape = $urandom_range(0, 2);
        case (shape)
            0: begin
                // Sparse to dense random edges.
                count = $urandom_range(0, 2 * vc);
                for (int k = 0; k < count; k++) begin
                    send_command(dfs_pkg::CMD_ADD, dfs_pkg::VERT_W'($urandom_range(1, vc)),
                                 dfs_pkg::VERT_W'($urandom_range(1, vc)));
                    if ($urandom_range(0, 5) == 0) begin
                        send_noise(vc);
                    end
                end
            end
            1: begin
                // A path through a shuffled vertex order drives the stack deep.
                for (int k = 0; k < vc; k++) begin
                    order[k] = k + 1;
                end
                for (int k = vc - 1; k > 0; k--) begin
                    swap_at        = $urandom_range(0, k);
                    held           = order[k];
                    order[k]       = order[swap_at];
                    order[swap_at] = held;
                end
                for (int k = 0; k + 1 < vc; k++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_command(dfs_pkg::CMD_ADD, dfs_pkg::VERT_W'(order[k]),
                                     dfs_pkg::VERT_W'(order[k+1]));
                    end else begin
                        send_command(dfs_pkg::CMD_ADD, dfs_pkg::VERT_W'(order[k+1]),
                                     dfs_pkg::VERT_W'(order[k]));
                    end
                end
            end
            default: begin
                // A star around a random center, plus noise.
                center = $urandom_range(1, vc);
                count  = $urandom_range(1, 6);
                for (int k = 0; k < count; k++) begin
                    send_command(dfs_pkg::CMD_ADD, dfs_pkg::VERT_W'(center),
                                 dfs_pkg::VERT_W'($urandom_range(1, vc)));
                end
                send_noise(vc);
            end
        endcase
        send_command(dfs_pkg::CMD_RUN, dfs_pkg::VERT_W'($urandom_range(0, 31)),
                     dfs_pkg::VERT_W'($urandom_range(0, 31)));
        if ($urandom_range(0, 7) == 0) begin
            send_command(dfs_pkg::CMD_RUN, '0, '0);
        end
    endtask

    // Reset value of the vertex count, the empty graph, accepted and rejected
    // edges, a self loop and the unused command code.
    task automatic test_edges_at_reset_count();
        send_command(dfs_pkg::CMD_RUN, '0, '0);
        send_command(dfs_pkg::CMD_ADD, 5'd1, 5'd16);
        send_command(dfs_pkg::CMD_ADD, 5'd16, 5'd2);
        send_command(dfs_pkg::CMD_ADD, 5'd5, 5'd5);
        send_command(dfs_pkg::CMD_ADD, 5'd3, 5'd4);
        send_command(dfs_pkg::CMD_ADD, 5'd4, 5'd16);
        send_command(dfs_pkg::CMD_ADD, 5'd0, 5'd7);
        send_command(dfs_pkg::CMD_ADD, 5'd7, 5'd0);
        send_command(dfs_pkg::CMD_ADD, 5'd17, 5'd3);
        send_command(dfs_pkg::CMD_ADD, 5'd31, 5'd31);
        send_command(CMD_UNUSED, 5'd6, 5'd8);
        send_command(dfs_pkg::CMD_RUN, 5'd31, 5'd31);
    endtask

    // Small counts, zero, and counts above the storage size. Also checks that
    // a clear leaves the count alone and that out-of-range edges are kept.
    task automatic test_vertex_count_extremes();
        write_vertex_count(5'd4);
        send_command(dfs_pkg::CMD_ADD, 5'd2, 5'd9);
        send_command(dfs_pkg::CMD_ADD, 5'd9, 5'd3);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
        send_command(dfs_pkg::CMD_CLEAR, 5'd31, 5'd31);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
        write_vertex_count(5'd1);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
        write_vertex_count(5'd0);
        send_command(dfs_pkg::CMD_ADD, 5'd1, 5'd2);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
        write_vertex_count(5'd31);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
        write_vertex_count(5'd17);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
    endtask

    // The result side holds off for a long stretch while commands keep coming,
    // so the block fills up and has to stall its command input.
    task automatic test_result_backpressure();
        write_vertex_count(5'd16);
        hold_req = HOLD_OFF_CYCLES;
        graph_round(dfs_pkg::MAX_VERTS);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
        send_command(dfs_pkg::CMD_ADD, 5'd8, 5'd12);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
        send_command(dfs_pkg::CMD_CLEAR, '0, '0);
        send_command(dfs_pkg::CMD_RUN, '0, '0);
    endtask

    // Random rounds under several register settings.
    task automatic test_random_graphs();
        int goal;
        int vc;
        int eff;

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: vc = 16;
                1: vc = $urandom_range(2, 15);
                2: vc = 31;
                3: vc = 1;
                4: vc = 0;
                default: vc = $urandom_range(1, 16);
            endcase
            write_vertex_count(dfs_pkg::VERT_W'(vc));
            eff  = (vc == 0 || vc > dfs_pkg::MAX_VERTS) ? dfs_pkg::MAX_VERTS : vc;
            goal = items_sent + ((vc == 0) ? 10 : (vc == 1) ? 20 : 36);
            while (items_sent < goal) begin
                graph_round(eff);
            end
        end
    endtask

    // Result receiver. It switches on its own between always ready, coin-flip
    // ready and a periodic pattern, and honors a long hold-off when asked.
    initial begin : result_sink
        int mode;
        int mode_left;
        int period;
        int tick;
        int hold_left;

        m_ready   = 1'b0;
        mode      = 0;
        mode_left = 0;
        period    = 2;
        tick      = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                    period    = $urandom_range(2, 5);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = ($urandom_range(0, 1) == 1);
                    default: m_ready = (tick % period == 0);
                endcase
            end
        end
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge aclk) begin : parent_check
        parent_beat_t want;

        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (parents_due.size() == 0) begin
                report_mismatch($sformatf("beat %0d: vertex %0d arrived with no run pending",
                                          beats_seen, m_vertex));
            end else begin
                want = parents_due.pop_front();
                if (m_vertex !== want.vertex) begin
                    report_mismatch($sformatf("beat %0d: vertex %0d, expected %0d",
                                              beats_seen, m_vertex, want.vertex));
                end
                if (m_parent_vertex !== want.parent_vertex) begin
                    report_mismatch($sformatf("beat %0d: parent of %0d is %0d, expected %0d",
                                              beats_seen, want.vertex, m_parent_vertex,
                                              want.parent_vertex));
                end
                if (m_last !== want.last) begin
                    report_mismatch($sformatf("beat %0d: last %0b on vertex %0d, expected %0b",
                                              beats_seen, m_last, want.vertex, want.last));
                end
            end
        end
    end

    initial begin
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_vertex_count = '0;
        s_valid          = 1'b0;
        s_cmd            = dfs_pkg::CMD_CLEAR;
        s_end_a          = '0;
        s_end_b          = '0;
        mismatch_count   = 0;
        beats_seen       = 0;
        items_sent       = 0;
        burst_left       = 0;
        hold_req         = 0;
        vcount_shadow    = dfs_pkg::VCOUNT_RESET;
        for (int k = 0; k < dfs_pkg::MAX_VERTS; k++) begin
            edge_rows[k] = '0;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_edges_at_reset_count();
        test_vertex_count_extremes();
        test_result_backpressure();
        test_random_graphs();
        settle_block();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
